@@ rtl/st1mfc_pkg.sv @@
// Shared types, layout offsets and limits for the ST1 module format checker.
// No dependencies; the front end, queue, back end and top import this package.

package st1mfc_pkg;

   // Pattern slots the position list may name
   localparam int MAX_PATTERNS = 32;
   localparam int IDX_W        = $clog2(MAX_PATTERNS);
   // Pattern counters must reach MAX_PATTERNS and the 52 patterns a saturated offset spans
   localparam int CNT_W = ($clog2(MAX_PATTERNS + 1) > 6) ? $clog2(MAX_PATTERNS + 1) : 6;

   // File layout
   localparam logic [14:0] POS_BASE   = 15'd1950;
   localparam logic [14:0] POSLEN_OFF = 15'd2462;
   localparam logic [14:0] DEL_OFF    = 15'd3007;
   localparam logic [14:0] PATLEN_OFF = 15'd3008;
   localparam logic [14:0] PAT_BASE   = 15'd3009;
   localparam logic [14:0] OFFSET_MAX = 15'h7FFF;

   // Positions inside one 130-byte sample
   localparam logic [7:0] LOC_NOISE = 8'd32;
   localparam logic [7:0] LOC_TONE  = 8'd64;
   localparam logic [7:0] LOC_LOOP  = 8'd128;
   localparam logic [7:0] SMP_LAST  = 8'd129;

   // Last byte of one 576-byte pattern
   localparam logic [9:0] PAT_LAST = 10'd575;

   // Byte limits
   localparam logic [7:0] VOL_MAX      = 8'd15;
   localparam logic [7:0] TONE_HI_MAX  = 8'h1F;
   localparam logic [7:0] LOOP_POS_MAX = 8'd32;
   localparam logic [7:0] LOOP_LEN_MAX = 8'd31;
   localparam logic [7:0] ORN_LO       = 8'd64;
   localparam logic [7:0] ORN_HI       = 8'd192;
   localparam logic [7:0] DELAY_MAX    = 8'd15;
   localparam logic [7:0] PATLEN_MIN   = 8'd11;
   localparam logic [7:0] PATLEN_MAX   = 8'd64;
   localparam logic [6:0] PITCH_MAX    = 7'h5F;

   // Byte classes handed from the front end to the back end
   typedef logic [3:0] kind_type;
   localparam kind_type KIND_FREE     = 4'd0;
   localparam kind_type KIND_VOL      = 4'd1;
   localparam kind_type KIND_NOISE    = 4'd2;
   localparam kind_type KIND_TONE_HI  = 4'd3;
   localparam kind_type KIND_LOOP_POS = 4'd4;
   localparam kind_type KIND_LOOP_LEN = 4'd5;
   localparam kind_type KIND_POS_PAT  = 4'd6;
   localparam kind_type KIND_POS_LEN  = 4'd7;
   localparam kind_type KIND_ORN      = 4'd8;
   localparam kind_type KIND_DELAY    = 4'd9;
   localparam kind_type KIND_PAT_LEN  = 4'd10;
   localparam kind_type KIND_NOTE     = 4'd11;

   // One classified byte
   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data;
      logic [7:0]       pos_idx;    // position number for a position-list byte
      logic [CNT_W-1:0] pat_idx;    // pattern the byte falls in
      logic [CNT_W-1:0] done_pats;  // patterns complete once this byte is in
      logic             sat;        // offset counter has saturated
      logic             last;
   } item_type;

   // Semitone of each note letter, notes 1 to 7
   function automatic logic [3:0] note_base(input logic [2:0] note);
      logic [3:0] base;
      case (note)
         3'd1: base = 4'd9;
         3'd2: base = 4'd11;
         3'd3: base = 4'd0;
         3'd4: base = 4'd2;
         3'd5: base = 4'd4;
         3'd6: base = 4'd5;
         3'd7: base = 4'd7;
         default: base = 4'd0;
      endcase
      return base;
   endfunction

endpackage

@@ rtl/st1mfc_front.sv @@
// Front end: accepts file bytes, tracks the offset and classifies each byte.
// Depends on st1mfc_pkg; feeds st1mfc_queue.

module st1mfc_front import st1mfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       q_full,
   output logic       q_push,
   output item_type   q_item
);

   logic [14:0]      off_ff, off_in;
   logic [7:0]       loc_ff, loc_in;
   logic [9:0]       pw_ff, pw_in;
   logic [CNT_W-1:0] pi_ff, pi_in;
   logic [1:0]       m3_ff, m3_in;
   logic [14:0]      pos_rel;
   logic             sat;
   logic             in_pat;
   logic             pw_wrap;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   assign sat     = (off_ff == OFFSET_MAX);
   assign in_pat  = (off_ff >= PAT_BASE);
   assign pw_wrap = (pw_ff == PAT_LAST);
   assign pos_rel = off_ff - POS_BASE;

   // Classify the byte by its offset
   always_comb begin
      q_item.kind      = KIND_FREE;
      q_item.data      = req_data_byte;
      q_item.pos_idx   = pos_rel[8:1];
      q_item.pat_idx   = pi_ff;
      q_item.done_pats = in_pat ? (pi_ff + CNT_W'(pw_wrap)) : '0;
      q_item.sat       = sat;
      q_item.last      = req_last_byte;
      if (off_ff < POS_BASE) begin
         if (loc_ff < LOC_NOISE) begin
            q_item.kind = KIND_VOL;
         end else if (loc_ff < LOC_TONE) begin
            q_item.kind = KIND_NOISE;
         end else if (loc_ff < LOC_LOOP) begin
            q_item.kind = loc_ff[0] ? KIND_TONE_HI : KIND_FREE;
         end else if (loc_ff == LOC_LOOP) begin
            q_item.kind = KIND_LOOP_POS;
         end else begin
            q_item.kind = KIND_LOOP_LEN;
         end
      end else if (off_ff < POSLEN_OFF) begin
         q_item.kind = pos_rel[0] ? KIND_FREE : KIND_POS_PAT;
      end else if (off_ff == POSLEN_OFF) begin
         q_item.kind = KIND_POS_LEN;
      end else if (off_ff < DEL_OFF) begin
         q_item.kind = KIND_ORN;
      end else if (off_ff == DEL_OFF) begin
         q_item.kind = KIND_DELAY;
      end else if (off_ff == PATLEN_OFF) begin
         q_item.kind = KIND_PAT_LEN;
      end else begin
         q_item.kind = (m3_ff == 2'd0) ? KIND_NOTE : KIND_FREE;
      end
   end

   // Advance the offset and the sample and pattern counters; freeze at saturation, clear on the last byte
   always_comb begin
      off_in = off_ff;
      loc_in = loc_ff;
      pw_in  = pw_ff;
      pi_in  = pi_ff;
      m3_in  = m3_ff;
      if (q_push) begin
         if (req_last_byte) begin
            off_in = '0;
            loc_in = '0;
            pw_in  = '0;
            pi_in  = '0;
            m3_in  = '0;
         end else if (!sat) begin
            off_in = off_ff + 15'd1;
            if (off_ff < POS_BASE) begin
               loc_in = (loc_ff == SMP_LAST) ? 8'd0 : loc_ff + 8'd1;
            end
            if (in_pat) begin
               pw_in = pw_wrap ? 10'd0 : pw_ff + 10'd1;
               pi_in = pi_ff + CNT_W'(pw_wrap);
               m3_in = (m3_ff == 2'd2) ? 2'd0 : m3_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= '0;
         loc_ff <= '0;
         pw_ff  <= '0;
         pi_ff  <= '0;
         m3_ff  <= '0;
      end else begin
         off_ff <= off_in;
         loc_ff <= loc_in;
         pw_ff  <= pw_in;
         pi_ff  <= pi_in;
         m3_ff  <= m3_in;
      end
   end

endmodule

@@ rtl/st1mfc_queue.sv @@
// Two-entry queue of classified bytes between the front and back ends.
// Depends on st1mfc_pkg for item_type.

module st1mfc_queue import st1mfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   // Move pointers and count on each beat in and out
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry; payload needs no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/st1mfc_back.sv @@
// Back end: applies the byte rules, keeps first positions, scans used patterns,
// and registers the verdict. Depends on st1mfc_pkg; fed by st1mfc_queue.

module st1mfc_back import st1mfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output logic     rsp_is_match
);

   logic [7:0]              pos_mem [MAX_PATTERNS];
   logic [MAX_PATTERNS-1:0] seen_ff, seen_in;
   logic                    failed_ff, failed_in;
   logic                    note_ff, note_in;
   logic [7:0]              limit_ff, limit_in;
   logic [CNT_W-1:0]        stored_ff, stored_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    any_used_ff, any_used_in;
   logic                    busy_ff, busy_in;
   logic [IDX_W-1:0]        addr_ff, addr_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [7:0]              rd_data_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_match_ff, rsp_match_in;

   logic             take;
   logic             fail_now;
   logic             found_now;
   logic             mem_we;
   logic [IDX_W-1:0] pat_slot;
   logic [3:0]       note;
   logic [6:0]       pitch;
   logic [CNT_W-1:0] stored_eff;
   logic             len_ok;
   logic             ok;

   // Take a beat unless it carries a verdict the output register cannot hold
   assign q_pop = q_valid && (!q_item.last || !rsp_valid_ff || rsp_ready);
   assign take  = q_pop;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_match = rsp_match_ff;

   assign pat_slot = IDX_W'(q_item.data - 8'd1);
   assign note     = q_item.data[7:4];
   assign pitch    = 7'(note_base(note[2:0]))
                   + {1'b0, q_item.data[2:0], 3'b000}
                   + {2'b00, q_item.data[2:0], 2'b00}
                   + 7'(q_item.data[3]);

   // Check the byte against the rule of its class
   always_comb begin
      fail_now  = 1'b0;
      found_now = 1'b0;
      mem_we    = 1'b0;
      case (q_item.kind)
         KIND_VOL:      fail_now = q_item.data > VOL_MAX;
         KIND_NOISE:    fail_now = q_item.data[5];
         KIND_TONE_HI:  fail_now = q_item.data > TONE_HI_MAX;
         KIND_LOOP_POS: fail_now = q_item.data > LOOP_POS_MAX;
         KIND_LOOP_LEN: fail_now = q_item.data > LOOP_LEN_MAX;
         KIND_POS_PAT: begin
            if (q_item.data == 8'd0 || {1'b0, q_item.data} > 9'(MAX_PATTERNS)) begin
               fail_now = 1'b1;
            end else if (!seen_ff[pat_slot]) begin
               mem_we = 1'b1;
            end
         end
         KIND_ORN:      fail_now = (q_item.data >= ORN_LO) && (q_item.data < ORN_HI);
         KIND_DELAY:    fail_now = (q_item.data == 8'd0) || (q_item.data > DELAY_MAX);
         KIND_PAT_LEN:  fail_now = (q_item.data < PATLEN_MIN) || (q_item.data > PATLEN_MAX);
         KIND_NOTE: begin
            if (q_item.pat_idx < stored_ff && note != 4'd0) begin
               if (note[3]) begin
                  fail_now = 1'b1;
               end else if ((note == 4'd2 || note == 4'd5) && q_item.data[3]) begin
                  fail_now = 1'b1;
               end else if (pitch > PITCH_MAX) begin
                  fail_now = 1'b1;
               end else begin
                  found_now = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Length test: enough whole patterns, or the offset ran past its range
   assign stored_eff = (stored_ff == '0) ? CNT_W'(1) : stored_ff;
   assign len_ok     = q_item.sat || (q_item.done_pats >= stored_eff);

   // Update state, run the used-pattern scan, and load the verdict
   always_comb begin
      failed_in    = failed_ff | (take & fail_now);
      note_in      = note_ff | (take & found_now);
      seen_in      = seen_ff;
      limit_in     = limit_ff;
      stored_in    = stored_ff;
      cnt_in       = cnt_ff;
      any_used_in  = any_used_ff;
      busy_in      = busy_ff;
      addr_in      = addr_ff;
      rd_valid_in  = busy_ff;
      rd_idx_in    = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_match_in = rsp_match_ff;
      ok           = !failed_in && note_in && any_used_ff && len_ok;

      if (take && mem_we) begin
         seen_in[pat_slot] = 1'b1;
      end

      // Step the scan address, one slot a cycle
      if (busy_ff) begin
         addr_in = addr_ff + IDX_W'(1);
         if (addr_ff == IDX_W'(MAX_PATTERNS - 1)) begin
            busy_in = 1'b0;
         end
      end

      // Count stored slots up to the highest used one
      if (rd_valid_ff && seen_ff[rd_idx_ff]) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (rd_data_ff <= limit_ff) begin
            stored_in   = cnt_ff + CNT_W'(1);
            any_used_in = 1'b1;
         end
      end

      // Start the scan at the position-length byte
      if (take && q_item.kind == KIND_POS_LEN) begin
         limit_in    = q_item.data;
         busy_in     = 1'b1;
         addr_in     = '0;
         rd_valid_in = 1'b0;
         cnt_in      = '0;
         stored_in   = '0;
         any_used_in = 1'b0;
      end

      // Deliver the verdict and clear for the next file
      if (take && q_item.last) begin
         rsp_valid_in = 1'b1;
         rsp_match_in = ok;
         failed_in    = 1'b0;
         note_in      = 1'b0;
         seen_in      = '0;
         limit_in     = '0;
         stored_in    = '0;
         cnt_in       = '0;
         any_used_in  = 1'b0;
         busy_in      = 1'b0;
         addr_in      = '0;
         rd_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         failed_ff    <= 1'b0;
         note_ff      <= 1'b0;
         seen_ff      <= '0;
         limit_ff     <= '0;
         stored_ff    <= '0;
         cnt_ff       <= '0;
         any_used_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         addr_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         failed_ff    <= failed_in;
         note_ff      <= note_in;
         seen_ff      <= seen_in;
         limit_ff     <= limit_in;
         stored_ff    <= stored_in;
         cnt_ff       <= cnt_in;
         any_used_ff  <= any_used_in;
         busy_ff      <= busy_in;
         addr_ff      <= addr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers hold without reset
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      rsp_match_ff <= rsp_match_in;
   end

   // First-position memory: written from the position list, read by the scan
   always_ff @(posedge clock) begin
      if (take && mem_we) begin
         pos_mem[pat_slot] <= q_item.pos_idx;
      end
      rd_data_ff <= pos_mem[addr_ff];
   end

endmodule

@@ rtl/st1_module_format_checker_top.sv @@
// Top level of the ST1 module format checker: front end, queue, back end.
// Depends on st1mfc_pkg, st1mfc_front, st1mfc_queue and st1mfc_back.
//
// Usage:
//   req_* carries the file bytes in order from offset zero, one beat per byte;
//   req_last_byte marks the final byte. rsp_* carries one beat per file with
//   rsp_is_match high when every layout, pattern, note and length check passed.
//   Throughput is one byte per cycle unless a verdict stalls; the offset decode
//   in the front end and the rule check in the back end are combinational.
//   rsp_valid is registered, loaded when the back end takes the last byte.
//   After the position-length byte a scan of the first-position memory, one
//   pattern slot a cycle, runs in the background; the following ornament
//   bytes leave it ample time.
//   If rsp_ready stays low the verdict holds in the output register; the back
//   end keeps checking bytes of the next file until its last byte, which waits
//   at the head of the two-entry queue; one more byte fills the queue, and then
//   req_ready drops.
//   Synchronous reset clears the offset, all pattern bookkeeping and any
//   pending verdict; after reset the block takes a new file at once.

module st1_module_format_checker_top import st1mfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_match
);

   logic     q_full;
   logic     q_push;
   item_type q_push_item;
   logic     q_pop;
   logic     q_valid;
   item_type q_item;

   st1mfc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (q_push_item)
   );

   st1mfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   st1mfc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_match (rsp_is_match)
   );

endmodule

@@ rtl/st1mfc_checker.sv @@
// Port-level assertions for the ST1 module format checker, bound to the top.
// Depends only on the top level's ports.

module st1mfc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last_byte,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_match
);

   // Count files whose last byte is in but whose verdict is not yet taken
   logic [2:0] pend_ff, pend_in;

   assign pend_in = pend_ff + 3'(req_valid && req_ready && req_last_byte)
                  - 3'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A stalled verdict beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_match))
      else $error("verdict changed or dropped while stalled");

   // No verdict without a last byte behind it
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 3'd0)
      else $error("verdict without a pending file");

   // Queue plus output register bound the files in flight
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd3)
      else $error("too many files in flight");

   // Reset empties the block
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind st1_module_format_checker_top st1mfc_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last_byte (req_last_byte),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_is_match  (rsp_is_match)
);
